FILE: rtl/core/dsr_pkg.sv
// Shared types, widths and codes for the difference std ratio block.
`timescale 1ns / 1ps

package dsr_pkg;

    // Field and state widths
    localparam int PRICE_W  = 24;
    localparam int CNT_W    = 13;
    localparam int VEL_W    = 25;
    localparam int ACCEL_W  = 26;
    localparam int VMAG_W   = 24;
    localparam int AMAG_W   = 25;
    localparam int VSUM_W   = 37;
    localparam int VSQ_W    = 61;
    localparam int ASUM_W   = 39;
    localparam int ASQ_W    = 63;
    localparam int RATIO_W  = 24;
    localparam int STAT_W   = 2;

    // Iterative unit widths
    localparam int ACC_W    = 100;
    localparam int MPLR_W   = 48;
    localparam int QUO_W    = 48;
    localparam int ROOT_W   = 24;
    localparam int STEP_W   = 6;
    localparam int FAC_W    = 2 * CNT_W;

    // Q8.16 result: squared ratio carries twice the fraction bits
    localparam int RATIO_FRAC = 16;
    localparam int SQ_FRAC    = 2 * RATIO_FRAC;
    localparam int DIV_PRE    = QUO_W - SQ_FRAC;

    // Parameter defaults
    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_PRICE_BITS  = 24;
    localparam int MIN_SAMPLES     = 4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FLAT  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVF   = 2'd3;

    // Iterative unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic               start;
        t_op                op;
        logic [STEP_W-1:0]  steps;
    } t_unit_ctl;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_FIN,
        ST_DONE
    } t_state;

    // Micro-operations run on the shared unit
    typedef enum logic [3:0] {
        U_SQV,
        U_SQA,
        U_M1S2,
        U_S1SQ,
        U_M2S4,
        U_S3SQ,
        U_F1,
        U_NF,
        U_F2,
        U_DF,
        U_DIV,
        U_SQRT
    } t_uop;

endpackage

FILE: rtl/core/diff_std_ratio_unit.sv
// Top level: running difference statistics and final std ratio sequencer.
`timescale 1ns / 1ps

// Takes one price series, one sample per transaction, and on the transaction
// with tlast returns one result: floor(sqrt(var(second diff) / var(first
// diff))) in unsigned Q8.16, saturated to 0xFFFFFF, with a status (ok, fewer
// than four samples, zero velocity spread, overflow). All arithmetic runs on
// one shared shift-add unit, one step per cycle. A missing sample or the first
// valid one needs no unit work; the second valid one runs one square (of the
// velocity), every later one two (velocity and acceleration). The item with
// tlast adds the final pass (eight multiplies, a 48-step divide and a 24-step
// square root); a short or overflowed series skips it, a flat one or a
// saturated ratio ends earlier than the full pass. The input is not ready
// while an item is being worked on. The result sits in an output register;
// the next series starts as soon as the result is handed over.
module diff_std_ratio_unit
    import dsr_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int PRICE_BITS  = DEF_PRICE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [23:0]         i_s_tdata,   // [23:0] price
    input  logic                i_s_tuser,   // [0] sample_valid
    input  logic                i_s_tlast,   // series_end
    // result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [23:0]         o_m_tdata,   // [23:0] ratio
    output logic [1:0]          o_m_tuser    // [1:0] status
);

    localparam logic [PRICE_W-1:0] PRICE_MASK =
        PRICE_W'((25'd1 << PRICE_BITS) - 25'd1);
    localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_SAMPLES);
    localparam int SH_V   = MPLR_W - PRICE_BITS;
    localparam int SH_A   = MPLR_W - PRICE_BITS - 1;
    localparam int SH_CNT = MPLR_W - CNT_W;
    localparam int SH_VS  = MPLR_W - VSUM_W;
    localparam int SH_AS  = MPLR_W - ASUM_W;
    localparam int SH_FAC = MPLR_W - FAC_W;

    // Series state
    logic [PRICE_W-1:0]         r_prev_price;
    logic signed [VEL_W-1:0]    r_prev_vel;
    logic [CNT_W-1:0]           r_count;
    logic signed [VSUM_W-1:0]   r_vel_sum;
    logic [VSQ_W-1:0]           r_vel_sq;
    logic signed [ASUM_W-1:0]   r_acc_sum;
    logic [ASQ_W-1:0]           r_acc_sq;
    logic                       r_ovf;
    logic                       r_last;

    // Sequencer
    t_state                     r_state, n_state;
    t_uop                       r_uop, n_uop;

    // Work registers
    logic [VMAG_W-1:0]          r_vmag;
    logic [AMAG_W-1:0]          r_amag;
    logic                       r_do_acc;
    logic [ACC_W-1:0]           r_t1;
    logic [ACC_W-1:0]           r_num;
    logic [ACC_W-1:0]           r_den;
    logic [FAC_W-1:0]           r_fac;
    logic [RATIO_W-1:0]         r_res_ratio;
    logic [STAT_W-1:0]          r_res_status;

    // Output register
    logic                       r_out_valid;
    logic [RATIO_W-1:0]         r_out_ratio;
    logic [STAT_W-1:0]          r_out_status;

    // Unit connections
    t_unit_ctl                  w_ctl;
    logic [ACC_W-1:0]           w_init;
    logic [ACC_W-1:0]           w_opnd;
    logic [MPLR_W-1:0]          w_mplr;
    logic                       w_done;
    logic [ACC_W-1:0]           w_acc;
    logic [QUO_W-1:0]           w_quo;

    logic                       s_acc;
    logic                       smp_take;
    logic                       out_free;
    logic                       flat_exit;
    logic                       sat_exit;
    logic [PRICE_W-1:0]         price;
    logic signed [VEL_W-1:0]    vel;
    logic signed [ACCEL_W-1:0]  accel;
    logic [VSUM_W-1:0]          vs_mag;
    logic [ASUM_W-1:0]          as_mag;
    logic [CNT_W-1:0]           m1;
    logic [CNT_W-1:0]           m2;

    dsr_iter_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_init  (w_init),
        .i_opnd  (w_opnd),
        .i_mplr  (w_mplr),
        .o_done  (w_done),
        .o_acc   (w_acc),
        .o_quo   (w_quo)
    );

    // Sample differences and magnitudes
    always_comb begin
        price    = i_s_tdata & PRICE_MASK;
        vel      = $signed({1'b0, price}) - $signed({1'b0, r_prev_price});
        accel    = ACCEL_W'(vel) - ACCEL_W'(r_prev_vel);
        vs_mag   = r_vel_sum[VSUM_W-1] ? VSUM_W'(-r_vel_sum) : VSUM_W'(r_vel_sum);
        as_mag   = r_acc_sum[ASUM_W-1] ? ASUM_W'(-r_acc_sum) : ASUM_W'(r_acc_sum);
        m1       = r_count - CNT_W'(1);
        m2       = r_count - CNT_W'(2);
        smp_take = i_s_tuser && (r_count < CNT_MAX);
        out_free = !r_out_valid || i_m_tready;
        flat_exit = (r_uop == U_M2S4) && (r_den == '0);
        sat_exit  = (r_uop == U_DIV) && ((r_num >> DIV_PRE) >= r_den);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_uop   = r_uop;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (smp_take && (r_count != '0)) begin
                        n_state = ST_ISSUE;
                        n_uop   = U_SQV;
                    end else if (i_s_tlast) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_ISSUE: begin
                n_state = (flat_exit || sat_exit) ? ST_DONE : ST_WAIT;
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_ISSUE;
                    unique case (r_uop)
                        U_SQV: begin
                            if (r_do_acc) begin
                                n_uop = U_SQA;
                            end else begin
                                n_state = r_last ? ST_FIN : ST_IDLE;
                            end
                        end
                        U_SQA:  n_state = r_last ? ST_FIN : ST_IDLE;
                        U_M1S2: n_uop = U_S1SQ;
                        U_S1SQ: n_uop = U_M2S4;
                        U_M2S4: n_uop = U_S3SQ;
                        U_S3SQ: n_uop = U_F1;
                        U_F1:   n_uop = U_NF;
                        U_NF:   n_uop = U_F2;
                        U_F2:   n_uop = U_DF;
                        U_DF:   n_uop = U_DIV;
                        U_DIV:  n_uop = U_SQRT;
                        U_SQRT: n_state = ST_DONE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FIN: begin
                if (r_ovf || (r_count < CNT_W'(MIN_SAMPLES))) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ISSUE;
                    n_uop   = U_M1S2;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and unit operands
    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        w_ctl.start = (r_state == ST_ISSUE) && !flat_exit && !sat_exit;
        w_ctl.op    = OP_MUL;
        w_ctl.steps = STEP_W'(CNT_W);
        w_init      = '0;
        w_opnd      = '0;
        w_mplr      = '0;
        unique case (r_uop)
            U_SQV: begin
                w_opnd      = ACC_W'(r_vmag);
                w_mplr      = MPLR_W'(r_vmag) << SH_V;
                w_ctl.steps = STEP_W'(PRICE_BITS);
            end
            U_SQA: begin
                w_opnd      = ACC_W'(r_amag);
                w_mplr      = MPLR_W'(r_amag) << SH_A;
                w_ctl.steps = STEP_W'(PRICE_BITS + 1);
            end
            U_M1S2: begin
                w_opnd = ACC_W'(r_vel_sq);
                w_mplr = MPLR_W'(m1) << SH_CNT;
            end
            U_S1SQ: begin
                w_opnd      = ACC_W'(vs_mag);
                w_mplr      = MPLR_W'(vs_mag) << SH_VS;
                w_ctl.steps = STEP_W'(VSUM_W);
            end
            U_M2S4: begin
                w_opnd = ACC_W'(r_acc_sq);
                w_mplr = MPLR_W'(m2) << SH_CNT;
            end
            U_S3SQ: begin
                w_opnd      = ACC_W'(as_mag);
                w_mplr      = MPLR_W'(as_mag) << SH_AS;
                w_ctl.steps = STEP_W'(ASUM_W);
            end
            U_F1: begin
                w_opnd = ACC_W'(m1);
                w_mplr = MPLR_W'(m1 - CNT_W'(1)) << SH_CNT;
            end
            U_F2: begin
                w_opnd = ACC_W'(m2);
                w_mplr = MPLR_W'(m2 - CNT_W'(1)) << SH_CNT;
            end
            U_NF: begin
                w_opnd      = r_num;
                w_mplr      = MPLR_W'(r_fac) << SH_FAC;
                w_ctl.steps = STEP_W'(FAC_W);
            end
            U_DF: begin
                w_opnd      = r_den;
                w_mplr      = MPLR_W'(r_fac) << SH_FAC;
                w_ctl.steps = STEP_W'(FAC_W);
            end
            U_DIV: begin
                // numerator * 2^32 over denominator, top part preloaded
                w_ctl.op    = OP_DIV;
                w_init      = r_num >> DIV_PRE;
                w_opnd      = r_den;
                w_mplr      = {r_num[DIV_PRE-1:0], {SQ_FRAC{1'b0}}};
                w_ctl.steps = STEP_W'(QUO_W);
            end
            U_SQRT: begin
                w_ctl.op    = OP_SQRT;
                w_mplr      = r_t1[MPLR_W-1:0];
                w_ctl.steps = STEP_W'(ROOT_W);
            end
            default: begin
                w_ctl.op = OP_MUL;
            end
        endcase
    end

    // Control and series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_uop        <= U_SQV;
            r_prev_price <= '0;
            r_prev_vel   <= '0;
            r_count      <= '0;
            r_vel_sum    <= '0;
            r_vel_sq     <= '0;
            r_acc_sum    <= '0;
            r_acc_sq     <= '0;
            r_ovf        <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;

            // accepted sample: differences and plain sums
            if (s_acc) begin
                r_last <= i_s_tlast;
                if (i_s_tuser) begin
                    if (!smp_take) begin
                        r_ovf <= 1'b1;
                    end else begin
                        if (r_count != '0) begin
                            r_vel_sum  <= r_vel_sum + VSUM_W'(vel);
                            r_prev_vel <= vel;
                            if (r_count != CNT_W'(1)) begin
                                r_acc_sum <= r_acc_sum + ASUM_W'(accel);
                            end
                        end
                        r_prev_price <= price;
                        r_count      <= r_count + CNT_W'(1);
                    end
                end
            end

            // squares from the shared unit
            if ((r_state == ST_WAIT) && w_done) begin
                if (r_uop == U_SQV) begin
                    r_vel_sq <= r_vel_sq + w_acc[VSQ_W-1:0];
                end else if (r_uop == U_SQA) begin
                    r_acc_sq <= r_acc_sq + w_acc[ASQ_W-1:0];
                end
            end

            // hand over result and start a fresh series
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid  <= 1'b1;
                r_prev_price <= '0;
                r_prev_vel   <= '0;
                r_count      <= '0;
                r_vel_sum    <= '0;
                r_vel_sq     <= '0;
                r_acc_sum    <= '0;
                r_acc_sq     <= '0;
                r_ovf        <= 1'b0;
                r_last       <= 1'b0;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Work registers and result payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_vmag   <= vel[VEL_W-1] ? VMAG_W'(-vel) : VMAG_W'(vel);
            r_amag   <= accel[ACCEL_W-1] ? AMAG_W'(-accel) : AMAG_W'(accel);
            r_do_acc <= (r_count >= CNT_W'(2));
        end

        if (r_state == ST_FIN) begin
            r_res_ratio  <= '0;
            r_res_status <= r_ovf ? STAT_OVF : STAT_SHORT;
        end

        if (r_state == ST_ISSUE) begin
            if (flat_exit) begin
                r_res_ratio  <= '0;
                r_res_status <= STAT_FLAT;
            end else if (sat_exit) begin
                r_res_ratio  <= '1;
                r_res_status <= STAT_OK;
            end
        end

        if ((r_state == ST_WAIT) && w_done) begin
            unique case (r_uop)
                U_M1S2, U_M2S4: r_t1 <= w_acc;
                U_S1SQ:         r_den <= r_t1 - w_acc;
                U_S3SQ:         r_num <= r_t1 - w_acc;
                U_F1, U_F2:     r_fac <= w_acc[FAC_W-1:0];
                U_NF:           r_num <= w_acc;
                U_DF:           r_den <= w_acc;
                U_DIV:          r_t1 <= ACC_W'(w_quo);
                U_SQRT: begin
                    r_res_ratio  <= w_quo[ROOT_W-1:0];
                    r_res_status <= STAT_OK;
                end
                default: ;
            endcase
        end

        if ((r_state == ST_DONE) && out_free) begin
            r_out_ratio  <= r_res_ratio;
            r_out_status <= r_res_status;
        end
    end

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_ratio;
    assign o_m_tuser  = r_out_status;

endmodule

FILE: rtl/core/dsr_iter_unit.sv
// Shared iterative unit: shift-add multiply, restoring divide and square root.
`timescale 1ns / 1ps

module dsr_iter_unit
    import dsr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_unit_ctl           i_ctl,
    input  logic [ACC_W-1:0]    i_init,
    input  logic [ACC_W-1:0]    i_opnd,
    input  logic [MPLR_W-1:0]   i_mplr,
    output logic                o_done,
    output logic [ACC_W-1:0]    o_acc,
    output logic [QUO_W-1:0]    o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    t_op                 r_op;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_opnd;
    logic [MPLR_W-1:0]   r_mplr;
    logic [QUO_W-1:0]    r_quo;

    logic [ACC_W-1:0]    lhs;
    logic [ACC_W-1:0]    addend;
    logic                cin;
    logic [ACC_W:0]      sum;
    logic                carry;

    // One wide adder serves all three operations
    always_comb begin
        unique case (r_op)
            OP_DIV: begin
                lhs    = {r_acc[ACC_W-2:0], r_mplr[MPLR_W-1]};
                addend = ~r_opnd;
                cin    = 1'b1;
            end
            OP_SQRT: begin
                // remainder takes two new bits, trial is 4*root + 1
                lhs    = {r_acc[ACC_W-3:0], r_mplr[MPLR_W-1 -: 2]};
                addend = ~ACC_W'({r_quo, 2'b01});
                cin    = 1'b1;
            end
            default: begin
                lhs    = {r_acc[ACC_W-2:0], 1'b0};
                addend = r_mplr[MPLR_W-1] ? r_opnd : '0;
                cin    = 1'b0;
            end
        endcase
        sum   = {1'b0, lhs} + {1'b0, addend} + (ACC_W+1)'(cin);
        carry = sum[ACC_W];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
                r_op   <= i_ctl.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc  <= i_init;
            r_opnd <= i_opnd;
            r_mplr <= i_mplr;
            r_quo  <= '0;
        end else if (r_busy) begin
            unique case (r_op)
                OP_DIV: begin
                    // keep the shifted remainder when the trial fails
                    r_acc  <= carry ? sum[ACC_W-1:0] : lhs;
                    r_quo  <= {r_quo[QUO_W-2:0], carry};
                    r_mplr <= {r_mplr[MPLR_W-2:0], 1'b0};
                end
                OP_SQRT: begin
                    r_acc  <= carry ? sum[ACC_W-1:0] : lhs;
                    r_quo  <= {r_quo[QUO_W-2:0], carry};
                    r_mplr <= {r_mplr[MPLR_W-3:0], 2'b00};
                end
                default: begin
                    r_acc  <= sum[ACC_W-1:0];
                    r_mplr <= {r_mplr[MPLR_W-2:0], 1'b0};
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_quo  = r_quo;

endmodule
